[rtl/sbb_pkg.sv]
// Shared types and constants for the smoothstep border blend block.
// No dependencies; every other file of the block refers to this package by scoped names.
package sbb_pkg;

   localparam int SAMPLE_BITS = 16;          // signed Q3.12 samples and levels
   localparam int MAX_DIM     = 4096;        // frame dimensions are capped here
   localparam int DIM_BITS    = 13;
   localparam int COORD_BITS  = 12;
   localparam int SIZE_BITS   = 8;           // one margin width
   localparam int FRAC_BITS   = 16;          // weight is Q1.16
   localparam int WEIGHT_BITS = FRAC_BITS + 1;
   localparam int CUBE_BITS   = 3 * SIZE_BITS;
   localparam int PROD_BITS   = WEIGHT_BITS + 1 + SAMPLE_BITS + 1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REQ_DATA_BITS  = ((2 * COORD_BITS + SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [DIM_BITS-1:0] DIM_CAP =
      DIM_BITS'(MAX_DIM > (2 ** DIM_BITS - 1) ? (2 ** DIM_BITS - 1) : MAX_DIM);
   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(256);
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(256);

   // Cycles from the weight unit's input register to its quotient register.
   localparam int WEIGHT_STAGES = 2 + WEIGHT_BITS;
   localparam int BLEND_STAGES  = 2;
   localparam int SIDES         = 4;
   // Input register, side decode register, weight unit, four blends.
   localparam int PIPE_DEPTH    = 2 + WEIGHT_STAGES + SIDES * BLEND_STAGES;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_MARGIN_SIZES = 3'd2,
      CSR_WEST_LEVEL   = 3'd3,
      CSR_EAST_LEVEL   = 3'd4,
      CSR_SOUTH_LEVEL  = 3'd5,
      CSR_NORTH_LEVEL  = 3'd6
   } csr_index_type;

   // What the decode stage hands to one side's weight unit.
   typedef struct packed {
      logic                 active;
      logic [SIZE_BITS-1:0] pos;
      logic [SIZE_BITS-1:0] size;
   } side_type;

endpackage

[rtl/sbb_weight.sv]
// Smoothstep weight unit for one side: n*n*(3s-2n)*65536/s^3 in Q1.16.
// Two multiply stages feed a restoring divider of one quotient bit per stage.
// Depends on sbb_pkg.
module sbb_weight #(
   parameter int EXTRA_DELAY = 0
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  sbb_pkg::side_type                     side,
   output logic [sbb_pkg::WEIGHT_BITS-1:0]       weight
);

   localparam int SB = sbb_pkg::SIZE_BITS;
   localparam int WB = sbb_pkg::WEIGHT_BITS;
   localparam int CB = sbb_pkg::CUBE_BITS;
   localparam int KB = SB + 2;

   logic [2*SB-1:0] sq_ff, sq_in;
   logic [2*SB-1:0] ssq_ff, ssq_in;
   logic [KB-1:0]   k_ff, k_in;
   logic [SB-1:0]   size_ff;
   logic            act1_ff;

   logic [2*SB+KB-1:0] t_full;
   logic [CB-1:0]      t_ff, d_ff;
   logic [3*SB-1:0]    d_full;
   logic               act2_ff;

   logic [CB-1:0] rem_ff [0:WB-1];
   logic [CB-1:0] rem_in [0:WB-1];
   logic [CB-1:0] den_ff [0:WB-1];
   logic [WB-1:0] quo_ff [0:WB-1];
   logic [WB-1:0] quo_in [0:WB-1];
   logic          act_ff [0:WB-1];
   logic [WB-1:0] gated;

   assign sq_in  = side.pos * side.pos;
   assign ssq_in = side.size * side.size;
   assign k_in   = KB'(side.size) * KB'(3) - KB'({side.pos, 1'b0});

   assign t_full = sq_ff * k_ff;
   assign d_full = ssq_ff * size_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff   <= sq_in;
         ssq_ff  <= ssq_in;
         k_ff    <= k_in;
         size_ff <= side.size;
         act1_ff <= side.active;
         // The numerator never exceeds s^3 because the distance is at most the size.
         t_ff    <= t_full[CB-1:0];
         d_ff    <= d_full[CB-1:0];
         act2_ff <= act1_ff;
      end
   end

   always_comb begin
      logic [CB:0] twice;
      logic        ge;
      ge        = (t_ff >= d_ff);
      rem_in[0] = ge ? t_ff - d_ff : t_ff;
      quo_in[0] = '0;
      quo_in[0][WB-1] = ge;
      for (int j = 1; j < WB; j++) begin
         twice     = {rem_ff[j-1], 1'b0};
         ge        = (twice >= {1'b0, den_ff[j-1]});
         rem_in[j] = ge ? CB'(twice - {1'b0, den_ff[j-1]}) : twice[CB-1:0];
         quo_in[j] = quo_ff[j-1];
         quo_in[j][WB-1-j] = ge;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= d_ff;
         act_ff[0] <= act2_ff;
         for (int j = 1; j < WB; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= den_ff[j-1];
            act_ff[j] <= act_ff[j-1];
         end
      end
   end

   // An inactive side gets full weight, which makes its blend return the sample unchanged.
   assign gated = act_ff[WB-1] ? quo_ff[WB-1] : WB'(1) << sbb_pkg::FRAC_BITS;

   generate
      if (EXTRA_DELAY == 0) begin : g_direct
         assign weight = gated;
      end else begin : g_delay
         logic [WB-1:0] wdly_ff [0:EXTRA_DELAY-1];
         always_ff @(posedge clock) begin
            if (advance) begin
               wdly_ff[0] <= gated;
               for (int j = 1; j < EXTRA_DELAY; j++) begin
                  wdly_ff[j] <= wdly_ff[j-1];
               end
            end
         end
         assign weight = wdly_ff[EXTRA_DELAY-1];
      end
   endgenerate

endmodule

[rtl/sbb_blend.sv]
// One border blend: level + round((weight * (value - level)) / 65536), two stages.
// The product is registered before the rounding add. Depends on sbb_pkg.
module sbb_blend (
   input  logic                                     clock,
   input  logic                                     advance,
   input  logic signed [sbb_pkg::SAMPLE_BITS-1:0]   value,
   input  logic signed [sbb_pkg::SAMPLE_BITS-1:0]   level,
   input  logic        [sbb_pkg::WEIGHT_BITS-1:0]   weight,
   output logic signed [sbb_pkg::SAMPLE_BITS-1:0]   value_out
);

   localparam int SB = sbb_pkg::SAMPLE_BITS;
   localparam int PB = sbb_pkg::PROD_BITS;
   localparam int FB = sbb_pkg::FRAC_BITS;
   localparam int HB = PB - FB;

   logic signed [SB:0]   diff;
   logic signed [PB-1:0] prod_ff, prod_in;
   logic signed [PB-1:0] rounded;
   logic signed [HB-1:0] upper;
   logic signed [HB-1:0] mix;
   logic signed [SB-1:0] value_ff;

   assign diff    = SB'(value) - SB'(level) + (SB+1)'(0);
   assign prod_in = $signed({1'b0, weight}) * diff;

   // Round half up, then floor by an arithmetic shift.
   assign rounded = prod_ff + PB'(1 << (FB - 1));
   assign upper   = $signed(rounded[PB-1:FB]);
   assign mix     = HB'(level) + upper;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         value_ff <= mix[SB-1:0];
      end
   end

   assign value_out = value_ff;

endmodule

[rtl/smoothstep_border_blend.sv]
// Smoothstep border blend: takes one heightmap sample per clock and pulls it toward the
// west, east, south and north border levels inside the configured margins. A request is
// accepted in every cycle unless the output is stalled. Each request passes through the
// per-side weight unit (two multiply stages and a 17-stage restoring divider) and then
// four blends of two stages each, applied in the order west, east, south, north. A skid
// register at the output holds one result while the pipeline freezes, so a stall on the
// response side loses nothing. The frame size, margin widths and levels may only be
// written while no request is in flight.
// Depends on sbb_pkg, sbb_weight and sbb_blend.
module smoothstep_border_blend (
   input  logic                                clock,
   input  logic                                reset,
   // column [11:0], row [23:12], sample_in [39:24]
   input  logic [sbb_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_out [15:0]
   output logic [sbb_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wen,
   input  logic [sbb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sbb_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int SB    = sbb_pkg::SAMPLE_BITS;
   localparam int CRB   = sbb_pkg::COORD_BITS;
   localparam int DB    = sbb_pkg::DIM_BITS;
   localparam int ZB    = sbb_pkg::SIZE_BITS;
   localparam int WB    = sbb_pkg::WEIGHT_BITS;
   localparam int DEPTH = sbb_pkg::PIPE_DEPTH;
   localparam int SDLY  = 1 + sbb_pkg::WEIGHT_STAGES;
   localparam int BS    = sbb_pkg::BLEND_STAGES;

   // Configuration registers.
   logic        [DB-1:0]                     width_ff, height_ff;
   logic        [sbb_pkg::CSR_DATA_BITS-1:0] margins_ff;
   logic signed [SB-1:0]                     west_ff, east_ff, south_ff, north_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= sbb_pkg::FRAME_WIDTH_RESET;
         height_ff  <= sbb_pkg::FRAME_HEIGHT_RESET;
         margins_ff <= '0;
         west_ff    <= '0;
         east_ff    <= '0;
         south_ff   <= '0;
         north_ff   <= '0;
      end else if (csr_wen) begin
         case (sbb_pkg::csr_index_type'(csr_index))
            sbb_pkg::CSR_FRAME_WIDTH:  width_ff   <= csr_wdata[DB-1:0];
            sbb_pkg::CSR_FRAME_HEIGHT: height_ff  <= csr_wdata[DB-1:0];
            sbb_pkg::CSR_MARGIN_SIZES: margins_ff <= csr_wdata;
            sbb_pkg::CSR_WEST_LEVEL:   west_ff    <= csr_wdata[SB-1:0];
            sbb_pkg::CSR_EAST_LEVEL:   east_ff    <= csr_wdata[SB-1:0];
            sbb_pkg::CSR_SOUTH_LEVEL:  south_ff   <= csr_wdata[SB-1:0];
            sbb_pkg::CSR_NORTH_LEVEL:  north_ff   <= csr_wdata[SB-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: everything moves together unless the skid register is occupied.
   logic              advance;
   logic              skid_vld_ff, skid_vld_in;
   logic [SB-1:0]     skid_data_ff;
   logic              vld_ff [0:DEPTH-1];

   assign advance    = !skid_vld_ff;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_tvalid;
         for (int j = 1; j < DEPTH; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   // Input register.
   logic        [CRB-1:0] col_ff, row_ff;
   logic signed [SB-1:0]  samp_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         col_ff  <= req_tdata[CRB-1:0];
         row_ff  <= req_tdata[2*CRB-1:CRB];
         samp_ff <= req_tdata[2*CRB+SB-1:2*CRB];
      end
   end

   // Side decode: distance into each margin and whether that margin applies.
   logic [DB-1:0]  wcap, hcap, dist_e, dist_n;
   logic [ZB-1:0]  size_w, size_e, size_s, size_n;
   logic           in_frame;
   sbb_pkg::side_type side_in [0:3];
   sbb_pkg::side_type side_ff [0:3];

   assign wcap   = (width_ff  > sbb_pkg::DIM_CAP) ? sbb_pkg::DIM_CAP : width_ff;
   assign hcap   = (height_ff > sbb_pkg::DIM_CAP) ? sbb_pkg::DIM_CAP : height_ff;
   assign size_w = margins_ff[ZB-1:0];
   assign size_e = margins_ff[2*ZB-1:ZB];
   assign size_s = margins_ff[3*ZB-1:2*ZB];
   assign size_n = margins_ff[4*ZB-1:3*ZB];
   assign in_frame = ({1'b0, col_ff} < wcap) && ({1'b0, row_ff} < hcap);
   // The east and north distances count the edge pixel as one.
   assign dist_e = wcap - {1'b0, col_ff};
   assign dist_n = hcap - {1'b0, row_ff};

   always_comb begin
      side_in[0].active = in_frame && (size_w != '0) && (col_ff < CRB'(size_w));
      side_in[1].active = in_frame && (size_e != '0) && (dist_e <= DB'(size_e));
      side_in[2].active = in_frame && (size_s != '0) && (row_ff < CRB'(size_s));
      side_in[3].active = in_frame && (size_n != '0) && (dist_n <= DB'(size_n));
      side_in[0].pos    = side_in[0].active ? col_ff[ZB-1:0] : '0;
      side_in[1].pos    = side_in[1].active ? dist_e[ZB-1:0] : '0;
      side_in[2].pos    = side_in[2].active ? row_ff[ZB-1:0] : '0;
      side_in[3].pos    = side_in[3].active ? dist_n[ZB-1:0] : '0;
      side_in[0].size   = size_w;
      side_in[1].size   = size_e;
      side_in[2].size   = size_s;
      side_in[3].size   = size_n;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 4; j++) begin
            side_ff[j] <= side_in[j];
         end
      end
   end

   // Weights; each later side waits one more blend so it meets the running value.
   logic [WB-1:0] weight_w, weight_e, weight_s, weight_n;

   sbb_weight #(.EXTRA_DELAY(0)) u_weight_w (
      .clock(clock), .advance(advance), .side(side_ff[0]), .weight(weight_w));
   sbb_weight #(.EXTRA_DELAY(BS)) u_weight_e (
      .clock(clock), .advance(advance), .side(side_ff[1]), .weight(weight_e));
   sbb_weight #(.EXTRA_DELAY(2 * BS)) u_weight_s (
      .clock(clock), .advance(advance), .side(side_ff[2]), .weight(weight_s));
   sbb_weight #(.EXTRA_DELAY(3 * BS)) u_weight_n (
      .clock(clock), .advance(advance), .side(side_ff[3]), .weight(weight_n));

   // The sample waits alongside the decode stage and the weight unit.
   logic signed [SB-1:0] sdly_ff [1:SDLY];

   always_ff @(posedge clock) begin
      if (advance) begin
         sdly_ff[1] <= samp_ff;
         for (int j = 2; j <= SDLY; j++) begin
            sdly_ff[j] <= sdly_ff[j-1];
         end
      end
   end

   logic signed [SB-1:0] after_w, after_e, after_s, after_n;

   sbb_blend u_blend_w (
      .clock(clock), .advance(advance), .value(sdly_ff[SDLY]), .level(west_ff),
      .weight(weight_w), .value_out(after_w));
   sbb_blend u_blend_e (
      .clock(clock), .advance(advance), .value(after_w), .level(east_ff),
      .weight(weight_e), .value_out(after_e));
   sbb_blend u_blend_s (
      .clock(clock), .advance(advance), .value(after_e), .level(south_ff),
      .weight(weight_s), .value_out(after_s));
   sbb_blend u_blend_n (
      .clock(clock), .advance(advance), .value(after_s), .level(north_ff),
      .weight(weight_n), .value_out(after_n));

   // Output skid: catches the last stage when the consumer stalls it.
   assign skid_vld_in = skid_vld_ff ? !rsp_tready : (vld_ff[DEPTH-1] && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_data_ff <= after_n;
      end
   end

   assign rsp_tvalid = skid_vld_ff || vld_ff[DEPTH-1];
   assign rsp_tdata  = sbb_pkg::RSP_DATA_BITS'(skid_vld_ff ? skid_data_ff : after_n);

endmodule

[rtl/sbb_checker.sv]
// Port-level checks for smoothstep_border_blend, bound to the top level.
// Depends on sbb_pkg and smoothstep_border_blend.
module sbb_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tready,
   input  logic [sbb_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response changed while stalled");

   // Reset empties the pipeline and the skid register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   // When a stalled response is stalled once more, the skid register is full, so no request is taken.
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) ##1 (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request accepted with a full skid register");

   // With the response side free, the block is always ready for a request.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |=> req_tready)
      else $error("request side stalled without a response stall");

endmodule

bind smoothstep_border_blend sbb_checker u_sbb_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready)
);
